/* hw/rtl/rmean_pkg.sv */
// ----------------------------------------------------------------------------
// rmean_pkg
// Shared constants, register codes, request types and control structs of the
// rolling mean block.
// ----------------------------------------------------------------------------
package rmean_pkg;

  localparam int MaxWindow    = 64;
  localparam int SampleBits   = 16;
  localparam int FractionBits = 8;

  localparam int AddrW    = $clog2(MaxWindow);
  localparam int LenW     = AddrW + 1;
  localparam int AgeW     = AddrW + 1;
  localparam int SumW     = SampleBits + AddrW;
  localparam int NumW     = SumW + FractionBits;
  localparam int DivCntW  = $clog2(NumW);
  localparam int MeanW    = 24;
  localparam int MagW     = ((NumW > MeanW) ? NumW : MeanW) + 1;
  localparam int PctW     = 7;
  localparam int AlignW   = 2;
  localparam int ProdW    = PctW + LenW;
  localparam int RamW     = SampleBits + 1;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam logic [CfgDataW-1:0] LenReset    = CfgDataW'(24);
  localparam logic [PctW-1:0]     CapReset    = PctW'(75);
  localparam logic [PctW-1:0]     PercentFull = PctW'(100);

  localparam logic [MagW-1:0]  MeanPosLimit = MagW'((64'd1 << (MeanW - 1)) - 64'd1);
  localparam logic [MagW-1:0]  MeanNegLimit = MagW'(64'd1 << (MeanW - 1));
  localparam logic [MeanW-1:0] MeanMax      = {1'b0, {(MeanW - 1){1'b1}}};
  localparam logic [MeanW-1:0] MeanMin      = {1'b1, {(MeanW - 1){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    RegWindowLength   = 2'd0,
    RegCapturePercent = 2'd1,
    RegAlignment      = 2'd2
  } reg_index_e;

  typedef enum logic [AlignW-1:0] {
    AlignTrailing = 2'd0,
    AlignCentred  = 2'd1,
    AlignLeading  = 2'd2
  } align_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         sample_missing;
    logic                         series_end;
  } in_t;

  typedef struct packed {
    logic signed [MeanW-1:0] mean_value;
    logic                    mean_missing;
    logic                    last_result;
  } out_t;

  typedef struct packed {
    logic write_item;
    logic pick_first;
    logic start;
    logic tap;
    logic check;
    logic div_step;
    logic load_out;
    logic next_age;
    logic clear_series;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
    logic last_tap;
    logic miss;
    logic div_done;
    logic out_free;
    logic more;
    logic series_end;
  } dp_status_t;

endpackage

/* hw/rtl/rmean_ram.sv */
// ----------------------------------------------------------------------------
// rmean_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rmean_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rmean_dp.sv */
// ----------------------------------------------------------------------------
// rmean_dp
// Datapath: configuration registers, sample window, window accumulator,
// bit-serial divider and output register.
// ----------------------------------------------------------------------------
module rmean_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [rmean_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rmean_pkg::CfgDataW-1:0]   cfg_data_i,
  input  rmean_pkg::in_t                   in_i,
  input  rmean_pkg::ctrl_cmd_t             cmd_i,
  output rmean_pkg::dp_status_t            status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output rmean_pkg::out_t                  out_o
);

  logic [rmean_pkg::CfgDataW-1:0] win_len_q;
  logic [rmean_pkg::PctW-1:0]     cap_q;
  logic [rmean_pkg::AlignW-1:0]   align_q;

  logic [rmean_pkg::LenW-1:0]  len;
  logic [rmean_pkg::AddrW-1:0] off;

  logic [rmean_pkg::AddrW-1:0] wp_q;
  logic [rmean_pkg::LenW-1:0]  seen_q;
  logic                        end_q;

  logic [rmean_pkg::AddrW-1:0] d_q;
  logic [rmean_pkg::AddrW-1:0] k_q;
  logic                        pend_q;
  logic signed [rmean_pkg::SumW-1:0] acc_q;
  logic [rmean_pkg::LenW-1:0]  present_q;

  logic [rmean_pkg::LenW-1:0]    rem_q;
  logic [rmean_pkg::NumW-1:0]    quo_q;
  logic                          neg_q;
  logic                          miss_q;
  logic [rmean_pkg::DivCntW-1:0] cnt_q;

  logic                        out_valid_q;
  rmean_pkg::out_t             out_q;

  logic signed [rmean_pkg::AgeW-1:0] lo;
  logic signed [rmean_pkg::AgeW-1:0] age;
  logic                        in_range;
  logic [rmean_pkg::AddrW-1:0] rd_addr;
  logic [rmean_pkg::RamW-1:0]  rd_data;
  logic signed [rmean_pkg::SampleBits-1:0] rd_sample;
  logic                        off_lt_seen;
  logic [rmean_pkg::AddrW-1:0] d_first;

  logic [rmean_pkg::ProdW-1:0] prod_present;
  logic [rmean_pkg::ProdW-1:0] prod_need;
  logic                        miss;
  logic [rmean_pkg::SumW-1:0]  abs_sum;
  logic [rmean_pkg::NumW-1:0]  num;
  logic [rmean_pkg::LenW:0]    trial;
  logic                        ge;
  logic [rmean_pkg::MagW-1:0]  mag;
  logic [rmean_pkg::MagW-1:0]  neg_mag;
  logic [rmean_pkg::MeanW-1:0] mean;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= rmean_pkg::LenReset;
      cap_q     <= rmean_pkg::CapReset;
      align_q   <= rmean_pkg::AlignTrailing;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rmean_pkg::RegWindowLength:   win_len_q <= cfg_data_i;
        rmean_pkg::RegCapturePercent: cap_q     <= cfg_data_i[rmean_pkg::PctW-1:0];
        rmean_pkg::RegAlignment:      align_q   <= cfg_data_i[rmean_pkg::AlignW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_len_q == '0) begin
      len = rmean_pkg::LenW'(1);
    end else if (win_len_q > rmean_pkg::CfgDataW'(rmean_pkg::MaxWindow)) begin
      len = rmean_pkg::LenW'(rmean_pkg::MaxWindow);
    end else begin
      len = rmean_pkg::LenW'(win_len_q);
    end
  end

  always_comb begin
    case (align_q)
      rmean_pkg::AlignCentred: off = rmean_pkg::AddrW'(len >> 1);
      rmean_pkg::AlignLeading: off = rmean_pkg::AddrW'(len - 1'b1);
      default:                 off = '0;
    endcase
  end

  // Series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      seen_q <= '0;
      end_q  <= 1'b0;
    end else if (cmd_i.clear_series) begin
      wp_q   <= '0;
      seen_q <= '0;
    end else if (cmd_i.write_item) begin
      wp_q  <= wp_q + 1'b1;
      end_q <= in_i.series_end;
      if (seen_q != '1) begin
        seen_q <= seen_q + 1'b1;
      end
    end
  end

  rmean_ram #(
    .Width (rmean_pkg::RamW),
    .Depth (rmean_pkg::MaxWindow)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_item),
    .waddr_i (wp_q),
    .wdata_i ({in_i.sample_missing, in_i.sample}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Window taps
  assign off_lt_seen = rmean_pkg::LenW'(off) < seen_q;
  assign d_first     = off_lt_seen ? off : rmean_pkg::AddrW'(seen_q - 1'b1);
  assign lo          = $signed({1'b0, d_q}) - $signed({1'b0, off});
  assign age         = lo + $signed({1'b0, k_q});
  assign in_range    = !age[rmean_pkg::AgeW-1] &&
                       (rmean_pkg::LenW'(age[rmean_pkg::AddrW-1:0]) < seen_q);
  assign rd_addr     = wp_q - rmean_pkg::AddrW'(1) - age[rmean_pkg::AddrW-1:0];
  assign rd_sample   = $signed(rd_data[rmean_pkg::SampleBits-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.tap && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick_first) begin
      d_q <= d_first;
    end else if (cmd_i.next_age) begin
      d_q <= d_q - 1'b1;
    end
    if (cmd_i.start) begin
      acc_q     <= '0;
      present_q <= '0;
      k_q       <= '0;
    end else begin
      if (cmd_i.tap) begin
        k_q <= k_q + 1'b1;
      end
      if (pend_q && !rd_data[rmean_pkg::RamW-1]) begin
        acc_q     <= acc_q + rmean_pkg::SumW'(rd_sample);
        present_q <= present_q + 1'b1;
      end
    end
  end

  // Capture test and divider
  assign prod_present = rmean_pkg::ProdW'(present_q) * rmean_pkg::ProdW'(rmean_pkg::PercentFull);
  assign prod_need    = rmean_pkg::ProdW'(cap_q) * rmean_pkg::ProdW'(len);
  assign miss         = (present_q == '0) || (prod_present < prod_need);
  assign abs_sum      = acc_q[rmean_pkg::SumW-1] ? rmean_pkg::SumW'(-acc_q)
                                                 : rmean_pkg::SumW'(acc_q);
  assign num          = rmean_pkg::NumW'(abs_sum) << rmean_pkg::FractionBits;
  assign trial        = {rem_q, quo_q[rmean_pkg::NumW-1]};
  assign ge           = trial >= (rmean_pkg::LenW + 1)'(present_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      miss_q <= miss;
      neg_q  <= acc_q[rmean_pkg::SumW-1];
      quo_q  <= num;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rmean_pkg::LenW'(trial - (rmean_pkg::LenW + 1)'(present_q))
                  : rmean_pkg::LenW'(trial);
      quo_q <= {quo_q[rmean_pkg::NumW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign mag     = rmean_pkg::MagW'(quo_q);
  assign neg_mag = rmean_pkg::MagW'(0) - mag;

  always_comb begin
    if (neg_q) begin
      mean = (mag > rmean_pkg::MeanNegLimit) ? rmean_pkg::MeanMin
                                             : neg_mag[rmean_pkg::MeanW-1:0];
    end else begin
      mean = (mag > rmean_pkg::MeanPosLimit) ? rmean_pkg::MeanMax
                                             : mag[rmean_pkg::MeanW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.mean_value   <= miss_q ? '0 : $signed(mean);
      out_q.mean_missing <= miss_q;
      out_q.last_result  <= end_q && (d_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign status_o.has_result = end_q || off_lt_seen;
  assign status_o.last_tap   = rmean_pkg::LenW'(k_q) == (len - 1'b1);
  assign status_o.miss       = miss;
  assign status_o.div_done   = cnt_q == rmean_pkg::DivCntW'(rmean_pkg::NumW - 1);
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.more       = end_q && (d_q != '0);
  assign status_o.series_end = end_q;

endmodule

/* hw/rtl/rmean_ctrl.sv */
// ----------------------------------------------------------------------------
// rmean_ctrl
// Controller: sequences the sample write of each request, then window taps,
// capture test, division (skipped on a failed test) and hand-off per result.
// ----------------------------------------------------------------------------
module rmean_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rmean_pkg::dp_status_t  status_i,
  output rmean_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StStart,
    StTap,
    StDrain,
    StCheck,
    StDivide,
    StLoad
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.write_item = 1'b1;
          state_d          = StDecide;
        end
      end
      StDecide: begin
        if (status_i.has_result) begin
          cmd_o.pick_first = 1'b1;
          state_d          = StStart;
        end else begin
          state_d = StIdle;
        end
      end
      StStart: begin
        cmd_o.start = 1'b1;
        state_d     = StTap;
      end
      StTap: begin
        cmd_o.tap = 1'b1;
        if (status_i.last_tap) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StCheck;
      end
      StCheck: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.miss ? StLoad : StDivide;
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (status_i.more) begin
            cmd_o.next_age = 1'b1;
            state_d        = StStart;
          end else begin
            cmd_o.clear_series = status_i.series_end;
            state_d            = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

/* hw/rtl/rolling_mean_with_capture_threshold.sv */
// ----------------------------------------------------------------------------
// rolling_mean_with_capture_threshold
// Windowed mean over a sample series with missing-value capture threshold.
// A result leaves after the window taps, the capture test and the 30-step
// divider; the divider is skipped when the capture test fails.
// One request at a time: a request may give no result, one result, or, at
// series end, further flushed results before the next request is taken.
// The window tap loop reads one RAM entry per cycle; the divider retires one
// quotient bit per cycle. Reset restores register defaults and an empty series.
// ----------------------------------------------------------------------------
module rolling_mean_with_capture_threshold (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rmean_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rmean_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rmean_pkg::in_t                 in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rmean_pkg::out_t                out_o
);

  rmean_pkg::ctrl_cmd_t  cmd;
  rmean_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rmean_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rmean_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in work");

  a_missing_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.mean_missing |-> out_o.mean_value == '0)
    else $error("missing result carries a nonzero mean");

  a_load_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.out_free)
    else $error("output register overwritten before hand-off");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rolling mean block. Sample series run under
// many window lengths, capture thresholds and alignments, including
// out-of-range settings, flushes of short series, index wrap and a long
// output stall. A scoreboard keeps its own copy of the window and the
// registers and compares every mean, missing flag and last flag in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rmean_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 200;
  localparam int StallCycles  = 1500;
  localparam int ItemTarget   = 360;
  localparam int ReportLimit  = 10;

  localparam logic [AlignW-1:0] AlignUnused = 2'd3;

  class mean_tracker;
    logic [CfgDataW-1:0]         win_len = LenReset;
    logic [PctW-1:0]             cap_pct = CapReset;
    logic [AlignW-1:0]           align   = AlignTrailing;
    logic signed [SampleBits-1:0] hist_val [MaxWindow];
    bit                           hist_gap [MaxWindow];
    logic [AddrW-1:0]             wr_ptr;
    logic [LenW-1:0]              seen;
    out_t                         owed_means [$];
    int                           errors = 0;

    function new();
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < MaxWindow; i++) begin
        hist_val[i] = '0;
        hist_gap[i] = 1'b1;
      end
      wr_ptr = '0;
      seen   = '0;
    endfunction

    function void set_register(reg_index_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegWindowLength:   win_len = data;
        RegCapturePercent: cap_pct = data;
        RegAlignment:      align = data[AlignW-1:0];
        default: ;
      endcase
    endfunction

    function int eff_len();
      if (win_len == 0) return 1;
      if (int'(win_len) > MaxWindow) return MaxWindow;
      return int'(win_len);
    endfunction

    function int eff_off(int len);
      if (align == AlignCentred) return len / 2;
      if (align == AlignLeading) return len - 1;
      return 0;
    endfunction

    function out_t window_mean(int age, int len, int off, bit is_last);
      int     gaps;
      int     present;
      int     idx;
      longint total;
      longint q;
      out_t   r;
      gaps  = 0;
      total = 0;
      for (int a = age - off; a <= age + len - 1 - off; a++) begin
        if (a < 0 || a >= int'(seen) || a >= MaxWindow) begin
          gaps++;
        end else begin
          idx = (int'(wr_ptr) + MaxWindow - 1 - a) % MaxWindow;
          if (hist_gap[idx]) gaps++;
          else total += hist_val[idx];
        end
      end
      present = len - gaps;
      r = '0;
      r.mean_missing = (present == 0) || (present * 100 < int'(cap_pct) * len);
      r.last_result  = is_last;
      if (!r.mean_missing) begin
        q = (total * (longint'(1) << FractionBits)) / present;
        if (q > longint'(MeanPosLimit)) q = longint'(MeanPosLimit);
        if (q < -longint'(MeanNegLimit)) q = -longint'(MeanNegLimit);
        r.mean_value = MeanW'(q);
      end
      return r;
    endfunction

    function void take_sample(in_t req);
      int len;
      int off;
      len = eff_len();
      off = eff_off(len);
      hist_val[wr_ptr] = req.sample_missing ? '0 : req.sample;
      hist_gap[wr_ptr] = req.sample_missing;
      wr_ptr++;
      if (seen < 7'd127) seen++;
      if (!req.series_end) begin
        if (int'(seen) > off) owed_means.push_back(window_mean(off, len, off, 1'b0));
      end else begin
        for (int d = off; d >= 0; d--) begin
          if (d < int'(seen)) owed_means.push_back(window_mean(d, len, off, d == 0));
        end
        restart();
      end
    endfunction

    function void note_fault(string what, out_t want, out_t got);
      errors++;
      if (errors <= ReportLimit) begin
        $display("%s: expected value %0d missing %0b last %0b, got value %0d missing %0b last %0b",
                 what, want.mean_value, want.mean_missing, want.last_result,
                 got.mean_value, got.mean_missing, got.last_result);
      end
    endfunction

    function void match_mean(out_t got);
      out_t want;
      if (owed_means.size() == 0) begin
        note_fault("result with no request owed", '0, got);
        return;
      end
      want = owed_means.pop_front();
      if (got.mean_value !== want.mean_value || got.mean_missing !== want.mean_missing ||
          got.last_result !== want.last_result) begin
        note_fault("mean mismatch", want, got);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_req = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_res;

  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  bit hold_start  = 1'b0;
  int hold_left   = 0;
  int cycle_count = 0;
  int items_sent  = 0;

  mean_tracker book = new();

  rolling_mean_with_capture_threshold uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) book.set_register(reg_index_e'(cfg_index), cfg_data);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) book.take_sample(in_req);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.match_mean(out_res);
  end

  // hold off the result side on request, else stall at random while idling is on
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = StallCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_idle_on && $urandom_range(99) < 26) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_t req_of(int value, bit gap, bit tail);
    in_t r;
    r.sample         = SampleBits'(value);
    r.sample_missing = gap;
    r.series_end     = tail;
    return r;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(9))
      0:       return -32768;
      1:       return 32767;
      2:       return int'($urandom_range(64)) - 32;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic int pick_gap_pct();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      3:       return 50;
      4:       return 90;
      default: return 100;
    endcase
  endfunction

  task automatic send_request(in_t req);
    if (in_idle_on && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic program_regs(logic [CfgDataW-1:0] len, logic [CfgDataW-1:0] cap,
                              logic [CfgDataW-1:0] al);
    reg_index_e          idx;
    logic [CfgDataW-1:0] val;
    for (int k = 0; k < 3; k++) begin
      case (k)
        0:       begin idx = RegWindowLength;   val = len; end
        1:       begin idx = RegCapturePercent; val = cap; end
        default: begin idx = RegAlignment;      val = al;  end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_series(int n, int gap_pct, bit closed);
    for (int i = 0; i < n; i++) begin
      send_request(req_of(pick_sample(), $urandom_range(99) < gap_pct, closed && i == n - 1));
    end
  endtask

  task automatic close_requests();
    in_valid <= 1'b0;
    while (book.owed_means.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    int len;
    int eff;
    int cap;
    int nser;
    int n;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset defaults
    send_request(req_of(32767, 1'b0, 1'b0));
    send_request(req_of(-32768, 1'b0, 1'b0));
    send_request(req_of(0, 1'b1, 1'b1));
    close_requests();

    program_regs(7'd4, 7'd50, CfgDataW'(AlignCentred));
    send_request(req_of(32767, 1'b0, 1'b0));
    send_request(req_of(32767, 1'b0, 1'b0));
    send_request(req_of(-32768, 1'b1, 1'b0));
    send_request(req_of(-32768, 1'b0, 1'b0));
    send_request(req_of(1, 1'b0, 1'b0));
    send_request(req_of(-1, 1'b0, 1'b1));
    close_requests();

    // series shorter than the offset, then a single-item series
    program_regs(7'd64, 7'd0, CfgDataW'(AlignLeading));
    send_request(req_of(100, 1'b0, 1'b0));
    send_request(req_of(-200, 1'b1, 1'b0));
    send_request(req_of(300, 1'b0, 1'b1));
    send_request(req_of(-7, 1'b0, 1'b1));
    close_requests();

    program_regs(7'd0, 7'd101, CfgDataW'(AlignUnused));
    send_request(req_of(5, 1'b0, 1'b0));
    send_request(req_of(6, 1'b0, 1'b1));
    close_requests();

    program_regs(7'd127, 7'd100, CfgDataW'(AlignCentred));
    send_request(req_of(0, 1'b1, 1'b0));
    send_request(req_of(0, 1'b1, 1'b1));
    close_requests();

    program_regs(7'd1, 7'd100, CfgDataW'(AlignTrailing));
    send_request(req_of(-32768, 1'b0, 1'b0));
    send_request(req_of(32767, 1'b0, 1'b1));
    close_requests();

    // long output stall while requests keep coming
    program_regs(7'd3, 7'd50, CfgDataW'(AlignTrailing));
    @(posedge clk);
    hold_start = 1'b1;
    @(negedge clk);
    run_series(30, 10, 1'b1);
    close_requests();

    // stretch without idling on either side
    @(posedge clk);
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    @(negedge clk);
    program_regs(7'd5, 7'd60, CfgDataW'(AlignCentred));
    run_series(40, 15, 1'b1);
    close_requests();
    @(posedge clk);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    @(negedge clk);

    // index wrap and position count saturation
    program_regs(7'd2, 7'd50, CfgDataW'(AlignLeading));
    run_series(130, 20, 1'b1);
    close_requests();
    program_regs(7'd64, 7'd80, CfgDataW'(AlignCentred));
    run_series(68, 10, 1'b1);
    close_requests();

    while (items_sent < ItemTarget) begin
      case ($urandom_range(19))
        0:       len = 0;
        1:       len = $urandom_range(127, 65);
        2:       len = 64;
        3, 4:    len = $urandom_range(63, 9);
        default: len = $urandom_range(8, 1);
      endcase
      case ($urandom_range(9))
        0:       cap = 0;
        1:       cap = 100;
        2:       cap = $urandom_range(127, 101);
        3, 4:    cap = $urandom_range(100, 0);
        default: cap = $urandom_range(90, 40);
      endcase
      eff = (len == 0) ? 1 : ((len > MaxWindow) ? MaxWindow : len);
      program_regs(CfgDataW'(len), CfgDataW'(cap), CfgDataW'($urandom_range(3)));
      nser = $urandom_range(3, 1);
      for (int s = 0; s < nser; s++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: n = $urandom_range(eff + 3, 1);
          6, 7, 8:          n = $urandom_range(2 * eff + 4, eff);
          default:          n = 1;
        endcase
        if (n > 80) n = 80;
        run_series(n, pick_gap_pct(), !(s == nser - 1 && $urandom_range(9) == 0));
      end
      close_requests();
    end

    if (book.errors == 0 && book.owed_means.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
